// File: sv/wffla_pkg.sv
package wffla_pkg;

    localparam int FREE_SLOTS    = 64;
    localparam int SLOT_W        = $clog2(FREE_SLOTS);
    localparam int ARENA_PAGES   = 16;
    localparam int PAGE_BYTES    = 4096;
    localparam int HEADER_BYTES  = 16;
    localparam int MAX_NEED      = PAGE_BYTES - HEADER_BYTES;
    localparam int ADDR_W        = 16;
    localparam int REQ_W         = 12;
    localparam int LEN_W         = 12;
    localparam int NEED_W        = REQ_W + 1;
    localparam int STAMP_W       = 32;
    localparam int PAGE_W        = 5;
    localparam int BLOCK_ENTRIES = 8192;
    localparam int BLK_W         = $clog2(BLOCK_ENTRIES);
    localparam int GRAIN_W       = 3;
    localparam int STATUS_W      = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic               used;
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   length;
        logic [STAMP_W-1:0] stamp;
    } slot_entry_t;

    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_idx;
        logic [ADDR_W-1:0]  wr_start;
        logic [LEN_W-1:0]   wr_length;
        logic [STAMP_W-1:0] wr_stamp;
        logic               clr_en;
        logic [SLOT_W-1:0]  clr_idx;
    } table_cmd_t;

    typedef struct packed {
        logic              wr_en;
        logic [BLK_W-1:0]  wr_idx;
        logic [LEN_W-1:0]  wr_data;
    } size_cmd_t;

endpackage

// File: sv/worst_fit_free_list_allocator_unit.sv
// Worst-fit allocator over an arena of 4096-byte pages, 16-byte block headers.
// Command channel: an item transfers on a rising edge with start high and busy
// low. opcode 0 allocates request_bytes (rounded up to 8), opcode 1 frees the
// block at object_address and puts it back in the free table.
// Result: done is high for exactly one cycle with granted_address, status
// (0 ok, 1 out of pages, 2 free table full) and pages_claimed. The receiver
// cannot stall; the result must be taken in that cycle.
// page_limit channel: a transfer on page_limit_valid (ready is always high)
// sets the number of pages that may be claimed; write it only while idle.
// Flow: a scan of all 64 free-table slots through one registered read port
// and one shared compare, then the decide state and, on a grant, the split
// state. A new command may transfer in the done cycle; the block takes no new
// command before it is through with the last one. busy is high from the
// cycle after a transfer up to the done cycle.
// Reset clears the free table valid bits, the insertion stamp and the page
// count, and sets page_limit to 16. No clearing pass is needed.
module worst_fit_free_list_allocator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic [wffla_pkg::REQ_W-1:0]          request_bytes,
    input  logic [wffla_pkg::ADDR_W-1:0]         object_address,
    output logic                                 done,
    output logic [wffla_pkg::ADDR_W-1:0]         granted_address,
    output logic [wffla_pkg::STATUS_W-1:0]       status,
    output logic [wffla_pkg::PAGE_W-1:0]         pages_claimed,
    input  logic                                 page_limit_valid,
    output logic                                 page_limit_ready,
    input  logic [wffla_pkg::PAGE_W-1:0]         page_limit
);
    import wffla_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_SPLIT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SLOT_W:0]     idx_reg, idx_next;
    logic                pv_reg, pv_next;
    logic [SLOT_W-1:0]   pidx_reg, pidx_next;
    logic                have_best_reg, have_best_next;
    logic [SLOT_W-1:0]   best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]   best_start_reg, best_start_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    logic [STAMP_W-1:0]  best_stamp_reg, best_stamp_next;
    logic                have_free_reg, have_free_next;
    logic [SLOT_W-1:0]   free_idx_reg, free_idx_next;
    logic                picked_reg, picked_next;
    logic [ADDR_W-1:0]   sel_start_reg, sel_start_next;
    logic [LEN_W-1:0]    sel_len_reg, sel_len_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [PAGE_W-1:0]   page_count_reg, page_count_next;
    logic [PAGE_W-1:0]   limit_reg;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   granted_reg, granted_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    slot_entry_t         entry;
    table_cmd_t          tbl_cmd;
    size_cmd_t           sz_cmd;
    logic [LEN_W-1:0]    sz_rdata;
    logic [PAGE_W-1:0]   eff_limit;
    logic [NEED_W-1:0]   rest;
    logic [NEED_W-1:0]   need_raw;
    logic                better;

    wffla_free_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg[SLOT_W-1:0]),
        .rd_entry (entry),
        .cmd      (tbl_cmd)
    );

    wffla_size_mem u_size (
        .clk     (clk),
        .rd_idx  (addr_reg[ADDR_W-1:GRAIN_W]),
        .rd_data (sz_rdata),
        .cmd     (sz_cmd)
    );

    assign eff_limit = (limit_reg < PAGE_W'(ARENA_PAGES)) ? limit_reg : PAGE_W'(ARENA_PAGES);
    assign need_raw  = {1'b0, request_bytes} + NEED_W'(7);
    assign rest      = {1'b0, sel_len_reg} - need_reg;
    assign better    = !have_best_reg || (entry.length > best_len_reg)
                       || ((entry.length == best_len_reg) && (entry.stamp < best_stamp_reg));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        need_next       = need_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        pv_next         = 1'b0;
        pidx_next       = idx_reg[SLOT_W-1:0];
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_stamp_next = best_stamp_reg;
        have_free_next  = have_free_reg;
        free_idx_next   = free_idx_reg;
        picked_next     = picked_reg;
        sel_start_next  = sel_start_reg;
        sel_len_next    = sel_len_reg;
        stamp_next      = stamp_reg;
        page_count_next = page_count_reg;
        done_next       = 1'b0;
        granted_next    = granted_reg;
        status_next     = status_reg;
        tbl_cmd         = '0;
        sz_cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = opcode;
                    need_next      = {need_raw[NEED_W-1:GRAIN_W], GRAIN_W'(0)};
                    addr_next      = object_address;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    have_free_next = 1'b0;
                    picked_next    = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pv_next = (idx_reg < (SLOT_W+1)'(FREE_SLOTS));
                if (pv_next)
                    idx_next = idx_reg + 1'b1;
                if (pv_reg)
                begin
                    if (entry.used && ({1'b0, entry.length} >= need_reg) && better)
                    begin
                        have_best_next  = 1'b1;
                        best_idx_next   = pidx_reg;
                        best_start_next = entry.start;
                        best_len_next   = entry.length;
                        best_stamp_next = entry.stamp;
                    end
                    if (!entry.used && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_idx_next  = pidx_reg;
                    end
                end
                if (idx_reg == (SLOT_W+1)'(FREE_SLOTS))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                granted_next = '0;
                status_next  = ST_OK;
                state_next   = S_IDLE;
                done_next    = 1'b1;
                if (op_reg == OP_FREE)
                begin
                    if (have_free_reg)
                    begin
                        tbl_cmd.wr_en     = 1'b1;
                        tbl_cmd.wr_idx    = free_idx_reg;
                        tbl_cmd.wr_start  = addr_reg;
                        tbl_cmd.wr_length = sz_rdata;
                        tbl_cmd.wr_stamp  = stamp_reg;
                        stamp_next        = stamp_reg + 1'b1;
                    end
                    else
                        status_next = ST_TABLE_FULL;
                end
                else if (need_reg > NEED_W'(MAX_NEED))
                    status_next = ST_NO_PAGES;
                else if (have_best_reg)
                begin
                    sel_start_next  = best_start_reg;
                    sel_len_next    = best_len_reg;
                    picked_next     = 1'b1;
                    tbl_cmd.clr_en  = 1'b1;
                    tbl_cmd.clr_idx = best_idx_reg;
                    done_next       = 1'b0;
                    state_next      = S_SPLIT;
                end
                else if (page_count_reg < eff_limit)
                begin
                    sel_start_next  = ADDR_W'(32'(page_count_reg) * PAGE_BYTES + HEADER_BYTES);
                    sel_len_next    = LEN_W'(MAX_NEED);
                    page_count_next = page_count_reg + 1'b1;
                    done_next       = 1'b0;
                    state_next      = S_SPLIT;
                end
                else
                    status_next = ST_NO_PAGES;
            end
            S_SPLIT:
            begin
                granted_next   = sel_start_reg;
                status_next    = ST_OK;
                sz_cmd.wr_en   = 1'b1;
                sz_cmd.wr_idx  = sel_start_reg[ADDR_W-1:GRAIN_W];
                sz_cmd.wr_data = need_reg[LEN_W-1:0];
                if (rest > NEED_W'(HEADER_BYTES))
                begin
                    tbl_cmd.wr_start  = sel_start_reg + ADDR_W'(need_reg) + ADDR_W'(HEADER_BYTES);
                    tbl_cmd.wr_length = rest[LEN_W-1:0] - LEN_W'(HEADER_BYTES);
                    tbl_cmd.wr_stamp  = stamp_reg;
                    // freed slot of the pick competes with the first empty one
                    if (picked_reg && (!have_free_reg || (best_idx_reg < free_idx_reg)))
                    begin
                        tbl_cmd.wr_en  = 1'b1;
                        tbl_cmd.wr_idx = best_idx_reg;
                    end
                    else if (have_free_reg)
                    begin
                        tbl_cmd.wr_en  = 1'b1;
                        tbl_cmd.wr_idx = free_idx_reg;
                    end
                    else
                        status_next = ST_TABLE_FULL;
                    if (tbl_cmd.wr_en)
                        stamp_next = stamp_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pv_reg         <= 1'b0;
            have_best_reg  <= 1'b0;
            have_free_reg  <= 1'b0;
            picked_reg     <= 1'b0;
            stamp_reg      <= '0;
            page_count_reg <= '0;
            limit_reg      <= PAGE_W'(ARENA_PAGES);
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pv_reg         <= pv_next;
            have_best_reg  <= have_best_next;
            have_free_reg  <= have_free_next;
            picked_reg     <= picked_next;
            stamp_reg      <= stamp_next;
            page_count_reg <= page_count_next;
            done_reg       <= done_next;
            if (page_limit_valid)
                limit_reg <= page_limit;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        addr_reg       <= addr_next;
        pidx_reg       <= pidx_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        best_stamp_reg <= best_stamp_next;
        free_idx_reg   <= free_idx_next;
        sel_start_reg  <= sel_start_next;
        sel_len_reg    <= sel_len_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign granted_address  = granted_reg;
    assign status           = status_reg;
    assign pages_claimed    = page_count_reg;
    assign page_limit_ready = 1'b1;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer not followed by busy");

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_claimed <= PAGE_W'(ARENA_PAGES))
        else $error("page count beyond arena");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NO_PAGES || status == ST_TABLE_FULL))
        else $error("undefined status code");

endmodule

// File: sv/wffla_free_table.sv
module wffla_free_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [wffla_pkg::SLOT_W-1:0]         rd_idx,
    output wffla_pkg::slot_entry_t               rd_entry,
    input  wffla_pkg::table_cmd_t                cmd
);
    import wffla_pkg::*;

    logic [ADDR_W-1:0]  start_mem [FREE_SLOTS];
    logic [LEN_W-1:0]   length_mem [FREE_SLOTS];
    logic [STAMP_W-1:0] stamp_mem [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] used_reg;
    logic               used_rd_reg;
    logic [ADDR_W-1:0]  start_rd_reg;
    logic [LEN_W-1:0]   length_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            start_mem[cmd.wr_idx]  <= cmd.wr_start;
            length_mem[cmd.wr_idx] <= cmd.wr_length;
            stamp_mem[cmd.wr_idx]  <= cmd.wr_stamp;
        end
        start_rd_reg  <= start_mem[rd_idx];
        length_rd_reg <= length_mem[rd_idx];
        stamp_rd_reg  <= stamp_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            used_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
                used_reg[cmd.clr_idx] <= 1'b0;
            if (cmd.wr_en)
                used_reg[cmd.wr_idx] <= 1'b1;
            used_rd_reg <= used_reg[rd_idx];
        end
    end

    assign rd_entry.used   = used_rd_reg;
    assign rd_entry.start  = start_rd_reg;
    assign rd_entry.length = length_rd_reg;
    assign rd_entry.stamp  = stamp_rd_reg;

endmodule

// File: sv/wffla_size_mem.sv
module wffla_size_mem (
    input  logic                              clk,
    input  logic [wffla_pkg::BLK_W-1:0]       rd_idx,
    output logic [wffla_pkg::LEN_W-1:0]       rd_data,
    input  wffla_pkg::size_cmd_t              cmd
);
    import wffla_pkg::*;

    logic [LEN_W-1:0] size_mem [BLOCK_ENTRIES];
    logic [LEN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            size_mem[cmd.wr_idx] <= cmd.wr_data;
        rd_data_reg <= size_mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: bench/alloc_result_checker.sv
`timescale 1ns / 1ps

module alloc_result_checker
    import wffla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                opcode,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   object_address,
    input  logic                done,
    input  logic [ADDR_W-1:0]   granted_address,
    input  logic [STATUS_W-1:0] status,
    input  logic [PAGE_W-1:0]   pages_claimed,
    input  logic                page_limit_valid,
    input  logic                page_limit_ready,
    input  logic [PAGE_W-1:0]   page_limit,
    output int                  faults,
    output int                  awaited
);

    localparam int PAGE_LIMIT_RESET = 16;
    localparam int GRAIN_MASK       = (1 << GRAIN_W) - 1;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   pages;
    } outcome_t;

    logic [ADDR_W-1:0]  slot_start [FREE_SLOTS];
    logic [LEN_W-1:0]   slot_len   [FREE_SLOTS];
    logic [STAMP_W-1:0] slot_stamp [FREE_SLOTS];
    bit                 slot_live  [FREE_SLOTS];
    logic [STAMP_W-1:0] next_stamp;
    logic [LEN_W-1:0]   object_len [BLOCK_ENTRIES];
    logic [PAGE_W-1:0]  claimed;
    logic [PAGE_W-1:0]  limit_reg;
    outcome_t           pending_outcomes [$];
    outcome_t           oldest;

    // lowest empty slot takes the block
    function automatic bit file_free_block(input logic [ADDR_W-1:0] at,
                                           input logic [LEN_W-1:0] len);
        for (int i = 0; i < FREE_SLOTS; i++)
        begin
            if (!slot_live[i])
            begin
                slot_live[i]  = 1'b1;
                slot_start[i] = at;
                slot_len[i]   = len;
                slot_stamp[i] = next_stamp;
                next_stamp    = next_stamp + 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // largest block that holds need, earliest stamp on a tie
    function automatic int worst_fit_slot(input logic [NEED_W-1:0] need);
        int best;
        best = -1;
        for (int i = 0; i < FREE_SLOTS; i++)
        begin
            if (slot_live[i] && slot_len[i] >= need)
            begin
                if (best < 0 || slot_len[i] > slot_len[best] ||
                    (slot_len[i] == slot_len[best] && slot_stamp[i] < slot_stamp[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic outcome_t predict_outcome(input logic op,
                                                 input logic [REQ_W-1:0] req,
                                                 input logic [ADDR_W-1:0] at);
        outcome_t          res;
        logic [NEED_W-1:0] need;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [PAGE_W-1:0] cap;
        int                slot;
        bit                have;
        res  = '0;
        have = 1'b0;
        base = '0;
        len  = '0;
        if (op == OP_FREE)
        begin
            if (!file_free_block(at, object_len[at[ADDR_W-1:GRAIN_W]]))
                res.status = ST_TABLE_FULL;
        end
        else
        begin
            need = ({1'b0, req} + NEED_W'(GRAIN_MASK)) & ~NEED_W'(GRAIN_MASK);
            cap  = (limit_reg < ARENA_PAGES) ? limit_reg : PAGE_W'(ARENA_PAGES);
            if (need <= MAX_NEED)
            begin
                slot = worst_fit_slot(need);
                if (slot >= 0)
                begin
                    base            = slot_start[slot];
                    len             = slot_len[slot];
                    slot_live[slot] = 1'b0;
                    have            = 1'b1;
                end
                else if (claimed < cap)
                begin
                    base    = ADDR_W'(claimed * PAGE_BYTES + HEADER_BYTES);
                    len     = LEN_W'(MAX_NEED);
                    claimed = claimed + 1'b1;
                    have    = 1'b1;
                end
            end
            if (!have)
                res.status = ST_NO_PAGES;
            else
            begin
                res.granted = base;
                object_len[base[ADDR_W-1:GRAIN_W]] = LEN_W'(need);
                // a remainder of a header or less is lost
                if (len - need > HEADER_BYTES)
                begin
                    if (!file_free_block(ADDR_W'(base + need + HEADER_BYTES),
                                         LEN_W'(len - need - HEADER_BYTES)))
                        res.status = ST_TABLE_FULL;
                end
            end
        end
        res.pages = claimed;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            next_stamp = '0;
            claimed    = '0;
            limit_reg  = PAGE_W'(PAGE_LIMIT_RESET);
            pending_outcomes.delete();
            faults     = 0;
            awaited    = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %0d/%0d/%0d",
                             $time, granted_address, status, pages_claimed);
                    faults++;
                end
                else
                begin
                    oldest = pending_outcomes.pop_front();
                    check_field("granted_address", oldest.granted, granted_address);
                    check_field("status", oldest.status, status);
                    check_field("pages_claimed", oldest.pages, pages_claimed);
                end
            end
            if (page_limit_valid && page_limit_ready)
                limit_reg = page_limit;
            if (start && !busy)
                pending_outcomes.push_back(predict_outcome(opcode, request_bytes,
                                                           object_address));
            awaited = pending_outcomes.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wffla_pkg::*;

    localparam int PHASES     = 6;
    localparam int GAP_MAX    = 90;
    localparam int SETTLE     = 80;
    localparam int KEEP_FREED = 128;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                start            = 1'b0;
    logic                opcode           = OP_ALLOC;
    logic [REQ_W-1:0]    request_bytes    = '0;
    logic [ADDR_W-1:0]   object_address   = '0;
    logic                page_limit_valid = 1'b0;
    logic [PAGE_W-1:0]   page_limit       = '0;
    logic                busy;
    logic                done;
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   pages_claimed;
    logic                page_limit_ready;
    int                  faults;
    int                  awaited;

    logic                ops_in_flight  [$];
    logic [ADDR_W-1:0]   live_objects   [$];
    logic [ADDR_W-1:0]   freed_objects  [$];
    logic                result_op;

    int phase_limit [PHASES] = '{1, 4, 16, 9, 16, 15};
    int phase_idle  [PHASES] = '{0, 74, 0, 28, 74, 0};
    int phase_items [PHASES] = '{150, 150, 200, 150, 100, 100};
    int phase_free  [PHASES] = '{40, 35, 30, 60, 45, 50};

    worst_fit_free_list_allocator_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .request_bytes    (request_bytes),
        .object_address   (object_address),
        .done             (done),
        .granted_address  (granted_address),
        .status           (status),
        .pages_claimed    (pages_claimed),
        .page_limit_valid (page_limit_valid),
        .page_limit_ready (page_limit_ready),
        .page_limit       (page_limit)
    );

    alloc_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .request_bytes    (request_bytes),
        .object_address   (object_address),
        .done             (done),
        .granted_address  (granted_address),
        .status           (status),
        .pages_claimed    (pages_claimed),
        .page_limit_valid (page_limit_valid),
        .page_limit_ready (page_limit_ready),
        .page_limit       (page_limit),
        .faults           (faults),
        .awaited          (awaited)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // granted objects become candidates for later frees
    always @(posedge clk)
    begin
        if (rst_n && done && ops_in_flight.size() > 0)
        begin
            result_op = ops_in_flight.pop_front();
            if (result_op == OP_ALLOC && status != ST_NO_PAGES)
                live_objects.push_back(granted_address);
        end
    end

    task automatic issue(input logic op, input logic [REQ_W-1:0] req,
                         input logic [ADDR_W-1:0] at);
        @(negedge clk);
        start          <= 1'b1;
        opcode         <= op;
        request_bytes  <= req;
        object_address <= at;
        do
            @(posedge clk);
        while (busy);
        ops_in_flight.push_back(op);
    endtask

    // idle time counts from the point the block could take a command
    task automatic pause(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        while (busy)
            @(negedge clk);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        @(negedge clk);
        page_limit_valid <= 1'b1;
        page_limit       <= PAGE_W'(value);
        do
            @(posedge clk);
        while (!page_limit_ready);
        @(negedge clk);
        page_limit_valid <= 1'b0;
    endtask

    // a free with free_pct chance, else an allocate; frees mostly of live objects, some unaligned, some double
    task automatic random_item(input int free_pct);
        int                k;
        int                r;
        logic [ADDR_W-1:0] at;
        logic [REQ_W-1:0]  req;
        req = REQ_W'($urandom);
        at  = ADDR_W'($urandom);
        if (live_objects.size() > 0 && $urandom_range(99) < free_pct)
        begin
            k  = $urandom_range(live_objects.size() - 1);
            at = live_objects[k];
            r  = $urandom_range(99);
            if (r < 90)
            begin
                live_objects.delete(k);
                if (r >= 80)
                    at[GRAIN_W-1:0] = GRAIN_W'($urandom_range(1, (1 << GRAIN_W) - 1));
                freed_objects.push_back(at);
                if (freed_objects.size() > KEEP_FREED)
                    void'(freed_objects.pop_front());
            end
            else if (freed_objects.size() > 0)
                at = freed_objects[$urandom_range(freed_objects.size() - 1)];
            issue(OP_FREE, req, at);
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 60)
                req = REQ_W'($urandom_range(1, 200));
            else if (r < 85)
                req = REQ_W'($urandom_range(8, 1024));
            else if (r < 95)
                req = REQ_W'($urandom_range(1024, MAX_NEED));
            issue(OP_ALLOC, req, at);
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(2);
        // oversize requests, exact page fits, no page left
        issue(OP_ALLOC, 4095, 16'h0000);
        issue(OP_ALLOC, 4089, 16'hFFFF);
        issue(OP_ALLOC, 4081, 16'h0000);
        issue(OP_ALLOC, 4080, 16'h0000);
        issue(OP_ALLOC, 4073, 16'h0000);
        issue(OP_ALLOC, 8, 16'h0000);
        // free back, one unaligned; tie goes to the older block
        issue(OP_FREE, 12'h000, ADDR_W'(HEADER_BYTES));
        issue(OP_FREE, 12'hFFF, ADDR_W'(PAGE_BYTES + HEADER_BYTES + 7));
        issue(OP_ALLOC, 1, 16'h0000);
        issue(OP_ALLOC, 0, 16'h0000);
        issue(OP_FREE, 12'h000, ADDR_W'(PAGE_BYTES + HEADER_BYTES + 7));
        issue(OP_FREE, 12'h000, ADDR_W'(HEADER_BYTES));
        issue(OP_FREE, 12'h000, ADDR_W'(HEADER_BYTES));
        issue(OP_ALLOC, 4000, 16'h0000);
        issue(OP_ALLOC, 17, 16'h0000);
        issue(OP_ALLOC, 4016, 16'h0000);
        issue(OP_FREE, 12'h000, 83);
        // remainder of exactly one header is lost
        issue(OP_ALLOC, 4000, 16'h0000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if ($urandom_range(99) < phase_idle[p])
                    pause($urandom_range(1, GAP_MAX));
                random_item(phase_free[p]);
            end
            drain();
        end

        repeat (SETTLE)
            @(posedge clk);
        if (faults == 0 && awaited == 0)
            $display("worst_fit_free_list_allocator_unit test passed");
        else
            $display("worst_fit_free_list_allocator_unit test failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("worst_fit_free_list_allocator_unit test failed");
        $finish;
    end

endmodule
